>>> sv/lsbx_pkg.sv
// Shared types and constants for the LSB stego payload extractor.
`default_nettype none

package lsbx_pkg;

  // Configuration register indexes
  localparam int unsigned CFG_IDX_W = 2;
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_HEADER_BYTES = 2'd0,
    CFG_MAGIC_FIRST  = 2'd1,
    CFG_MAGIC_SECOND = 2'd2
  } cfg_idx_t;

  // Reset values of the configuration registers
  localparam logic [7:0] HEADER_BYTES_RST = 8'd54;
  localparam logic [7:0] MAGIC_FIRST_RST  = 8'd35;
  localparam logic [7:0] MAGIC_SECOND_RST = 8'd42;

  // Field widths of the hidden stream
  localparam int unsigned LEN_BITS  = 32;
  localparam int unsigned CHAR_BITS = 8;

  // Parser phases
  typedef enum logic [2:0] {
    PH_HEADER  = 3'd0,
    PH_MAGIC   = 3'd1,
    PH_EXT_LEN = 3'd2,
    PH_EXT_CHR = 3'd3,
    PH_PAY_LEN = 3'd4,
    PH_PAY_CHR = 3'd5,
    PH_DONE    = 3'd6
  } phase_t;

  // Result kinds
  typedef enum logic [2:0] {
    KIND_EXT_LEN   = 3'd0,
    KIND_EXT_CHR   = 3'd1,
    KIND_PAY_LEN   = 3'd2,
    KIND_PAY_CHR   = 3'd3,
    KIND_BAD_MAGIC = 3'd4,
    KIND_TRUNC     = 3'd5
  } kind_t;

  // One parser step's result
  typedef struct packed {
    logic        have;
    kind_t       kind;
    logic [31:0] value;
    logic        fin;
  } result_t;

endpackage

`default_nettype wire

>>> sv/lsb_stego_payload_extractor.sv
// Top level: request pipeline, configuration registers and result register.
`default_nettype none

// Takes one image byte per clock and gives zero or one result per byte: the
// byte is held in an input register, the parser works out its next state and
// any result combinationally, and the result lands in an output register as
// the parser state advances. Throughput is one byte per cycle as long as
// out_stall is low. A stalled result holds the input side only once the
// input register is also full. Configuration writes take effect on the next
// clock and are meant to happen while idle.
module lsb_stego_payload_extractor
  import lsbx_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  // configuration
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [7:0]           cfg_wdata,
  // image byte requests
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire logic [7:0]           in_image_byte,
  input  wire logic                 in_start_of_image,
  input  wire logic                 in_end_of_image,
  // result requests
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output logic [2:0]                out_result_kind,
  output logic [31:0]               out_result_value,
  output logic                      out_final_result
);

  logic [7:0]  header_bytes_r;
  logic [7:0]  magic_first_r;
  logic [7:0]  magic_second_r;

  logic        s1_valid_r;
  logic        s1_bit_r;
  logic        s1_sof_r;
  logic        s1_eoi_r;

  logic        out_valid_r;
  kind_t       out_kind_r;
  logic [31:0] out_value_r;
  logic        out_fin_r;

  logic        out_ready;
  logic        in_take;
  logic        fire;
  result_t     res;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      header_bytes_r <= HEADER_BYTES_RST;
      magic_first_r  <= MAGIC_FIRST_RST;
      magic_second_r <= MAGIC_SECOND_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_HEADER_BYTES: header_bytes_r <= cfg_wdata;
        CFG_MAGIC_FIRST:  magic_first_r  <= cfg_wdata;
        CFG_MAGIC_SECOND: magic_second_r <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  // Handshake
  assign out_ready = !out_valid_r || !out_stall;
  assign fire      = s1_valid_r && out_ready;
  assign in_stall  = s1_valid_r && !out_ready;
  assign in_take   = in_valid && !in_stall;

  // Input register; only the hidden bit of the byte is kept
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_take) begin
      s1_valid_r <= 1'b1;
    end else if (fire) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_bit_r <= in_image_byte[0];
      s1_sof_r <= in_start_of_image;
      s1_eoi_r <= in_end_of_image;
    end
  end

  lsbx_parser u_parser (
    .clk          (clk),
    .rst_n        (rst_n),
    .step_en      (fire),
    .hid_bit      (s1_bit_r),
    .sof          (s1_sof_r),
    .eoi          (s1_eoi_r),
    .header_bytes (header_bytes_r),
    .magic_first  (magic_first_r),
    .magic_second (magic_second_r),
    .res          (res)
  );

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (fire && res.have) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && res.have) begin
      out_kind_r  <= res.kind;
      out_value_r <= res.value;
      out_fin_r   <= res.fin;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_result_kind  = out_kind_r;
  assign out_result_value = out_value_r;
  assign out_final_result = out_fin_r;

endmodule

`default_nettype wire

>>> sv/lsbx_parser.sv
// Parser state and step logic for the hidden bit stream.
`default_nettype none

module lsbx_parser
  import lsbx_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       step_en,
  input  wire logic       hid_bit,
  input  wire logic       sof,
  input  wire logic       eoi,
  input  wire logic [7:0] header_bytes,
  input  wire logic [7:0] magic_first,
  input  wire logic [7:0] magic_second,
  output result_t         res
);

  phase_t      phase_r, phase_nxt;
  logic [7:0]  hdr_cnt_r, hdr_cnt_nxt;
  logic [4:0]  bit_cnt_r, bit_cnt_nxt;
  logic [31:0] shift_r, shift_nxt;
  logic [30:0] items_r, items_nxt;

  // Working copies after an optional restart
  phase_t      ph_w;
  logic [7:0]  hc_w;
  logic [4:0]  bc_w;
  logic [31:0] sh_w;
  logic [31:0] sh_g;
  logic [30:0] it_w;
  logic [30:0] it_dec;
  logic        magic_ok;

  // State registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_HEADER;
      hdr_cnt_r <= '0;
      bit_cnt_r <= '0;
      shift_r   <= '0;
      items_r   <= '0;
    end else if (step_en) begin
      phase_r   <= phase_nxt;
      hdr_cnt_r <= hdr_cnt_nxt;
      bit_cnt_r <= bit_cnt_nxt;
      shift_r   <= shift_nxt;
      items_r   <= items_nxt;
    end
  end

  // Next state and result for one image byte
  always_comb begin
    ph_w = sof ? PH_HEADER : phase_r;
    hc_w = sof ? 8'd0 : hdr_cnt_r;
    bc_w = sof ? 5'd0 : bit_cnt_r;
    sh_w = sof ? 32'd0 : shift_r;
    it_w = sof ? 31'd0 : items_r;

    phase_nxt   = ph_w;
    hdr_cnt_nxt = hc_w;
    bit_cnt_nxt = bc_w;
    shift_nxt   = sh_w;
    items_nxt   = it_w;
    res         = '{have: 1'b0, kind: KIND_EXT_LEN, value: 32'd0, fin: 1'b0};

    // header skip; the first hidden bit is gathered on the same byte
    if (ph_w == PH_HEADER) begin
      if (hc_w < header_bytes) begin
        hdr_cnt_nxt = hc_w + 8'd1;
      end else begin
        ph_w      = PH_MAGIC;
        phase_nxt = PH_MAGIC;
      end
    end

    sh_g     = sh_w | (32'(hid_bit) << bc_w);
    magic_ok = (sh_g[7:0] == magic_first) && (sh_g[15:8] == magic_second);
    it_dec   = (it_w != 31'd0) ? (it_w - 31'd1) : 31'd0;

    unique case (ph_w)
      PH_MAGIC: begin
        if (bc_w == 5'd15) begin
          bit_cnt_nxt = '0;
          shift_nxt   = '0;
          if (magic_ok) begin
            phase_nxt = PH_EXT_LEN;
          end else begin
            res       = '{have: 1'b1, kind: KIND_BAD_MAGIC, value: 32'd0, fin: 1'b1};
            phase_nxt = PH_DONE;
          end
        end else begin
          bit_cnt_nxt = bc_w + 5'd1;
          shift_nxt   = sh_g;
        end
      end
      PH_EXT_LEN, PH_PAY_LEN: begin
        if (bc_w == 5'(LEN_BITS - 1)) begin
          // a length with the sign bit set counts no items
          items_nxt   = sh_g[31] ? 31'd0 : sh_g[30:0];
          bit_cnt_nxt = '0;
          shift_nxt   = '0;
          res.have    = 1'b1;
          res.value   = sh_g;
          if (ph_w == PH_EXT_LEN) begin
            res.kind  = KIND_EXT_LEN;
            phase_nxt = (items_nxt != 31'd0) ? PH_EXT_CHR : PH_PAY_LEN;
          end else begin
            res.kind = KIND_PAY_LEN;
            if (items_nxt != 31'd0) begin
              phase_nxt = PH_PAY_CHR;
            end else begin
              res.fin   = 1'b1;
              phase_nxt = PH_DONE;
            end
          end
        end else begin
          bit_cnt_nxt = bc_w + 5'd1;
          shift_nxt   = sh_g;
        end
      end
      PH_EXT_CHR, PH_PAY_CHR: begin
        if (bc_w == 5'(CHAR_BITS - 1)) begin
          bit_cnt_nxt = '0;
          shift_nxt   = '0;
          items_nxt   = it_dec;
          res.have    = 1'b1;
          res.value   = {24'd0, sh_g[7:0]};
          res.kind    = (ph_w == PH_EXT_CHR) ? KIND_EXT_CHR : KIND_PAY_CHR;
          if (it_dec == 31'd0) begin
            if (ph_w == PH_EXT_CHR) begin
              phase_nxt = PH_PAY_LEN;
            end else begin
              res.fin   = 1'b1;
              phase_nxt = PH_DONE;
            end
          end
        end else begin
          bit_cnt_nxt = bc_w + 5'd1;
          shift_nxt   = sh_g;
        end
      end
      default: begin
        // header or done: nothing gathered
      end
    endcase

    // early end of image overrides whatever this byte produced, unless the byte already ended the decode
    if (eoi && (phase_nxt != PH_DONE)) begin
      res         = '{have: 1'b1, kind: KIND_TRUNC, value: 32'd0, fin: 1'b1};
      phase_nxt   = PH_DONE;
      bit_cnt_nxt = '0;
      shift_nxt   = '0;
    end
  end

endmodule

`default_nettype wire

>>> sv/lsbx_checker.sv
// Port-level checks on the extractor's result channel, bound to the top level.
`default_nettype none

module lsbx_checker
  import lsbx_pkg::*;
(
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        out_valid,
  input wire logic        out_stall,
  input wire logic [2:0]  out_result_kind,
  input wire logic [31:0] out_result_value,
  input wire logic        out_final_result
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_result_kind) &&
      $stable(out_result_value) && $stable(out_final_result))
    else $error("stalled result changed");

  // errors carry zero value and end the decode
  a_err_form: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_result_kind == KIND_BAD_MAGIC || out_result_kind == KIND_TRUNC)
      |-> out_result_value == 32'd0 && out_final_result)
    else $error("error result malformed");

  // characters are eight bits wide
  a_char_width: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_result_kind == KIND_EXT_CHR || out_result_kind == KIND_PAY_CHR)
      |-> out_result_value[31:8] == 24'd0)
    else $error("character wider than eight bits");

  // extension results never end the decode
  a_ext_not_final: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_result_kind == KIND_EXT_LEN || out_result_kind == KIND_EXT_CHR)
      |-> !out_final_result)
    else $error("extension result marked final");

  // no result right after reset
  a_reset_idle: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind lsb_stego_payload_extractor lsbx_checker u_lsbx_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .out_valid        (out_valid),
  .out_stall        (out_stall),
  .out_result_kind  (out_result_kind),
  .out_result_value (out_result_value),
  .out_final_result (out_final_result)
);

`default_nettype wire

>>> test/tb_lsb_stego_payload_extractor.sv
// Testbench for the LSB stego payload extractor: directed and random images, scoreboard check.
`timescale 1ns / 1ps

module tb_lsb_stego_payload_extractor;
  import lsbx_pkg::*;

  // one decoded field or error as the extractor should report it
  typedef struct {
    kind_t       kind;
    logic [31:0] value;
    logic        fin;
  } decoded_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [7:0]           cfg_wdata = '0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic [7:0]           in_image_byte = '0;
  logic                 in_start_of_image = 1'b0;
  logic                 in_end_of_image = 1'b0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic [2:0]           out_result_kind;
  logic [31:0]          out_result_value;
  logic                 out_final_result;

  lsb_stego_payload_extractor dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_wdata         (cfg_wdata),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_image_byte     (in_image_byte),
    .in_start_of_image (in_start_of_image),
    .in_end_of_image   (in_end_of_image),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_result_kind   (out_result_kind),
    .out_result_value  (out_result_value),
    .out_final_result  (out_final_result)
  );

  always #5 clk = ~clk;

  // register copies seen by the decoder model
  logic [7:0] cfg_hdr = HEADER_BYTES_RST;
  logic [7:0] cfg_m0  = MAGIC_FIRST_RST;
  logic [7:0] cfg_m1  = MAGIC_SECOND_RST;

  // decoder model state
  phase_t      parse_at = PH_HEADER;
  logic [7:0]  hdr_seen = '0;
  logic [4:0]  nbits    = '0;
  logic [31:0] shreg    = '0;
  logic [31:0] left     = '0;

  decoded_t    pending[$];
  logic [7:0]  carrier[$];
  bit          steady = 1'b0;
  int          errors = 0;
  int          bytes_sent = 0;
  int          results_due = 0;
  int          checked = 0;
  int          n_trunc = 0;
  int          n_magic = 0;

  // decoder model: advance on one accepted image byte, queue any decoded field
  task automatic decode_byte(input logic [7:0] b, input logic sof, input logic eoi);
    logic     hit;
    logic     ok;
    decoded_t d;
    hit = 1'b0;
    d.kind = KIND_EXT_LEN;
    d.value = '0;
    d.fin = 1'b0;
    if (sof) begin
      parse_at = PH_HEADER;
      hdr_seen = '0;
      nbits = '0;
      shreg = '0;
      left = '0;
    end
    if (parse_at == PH_HEADER) begin
      if (hdr_seen < cfg_hdr) hdr_seen++;
      else parse_at = PH_MAGIC;
    end
    if (parse_at >= PH_MAGIC && parse_at <= PH_PAY_CHR) begin
      shreg = shreg | (32'(b[0]) << nbits);
      case (parse_at)
        PH_MAGIC: begin
          if (nbits == 5'd15) begin
            ok = shreg[7:0] == cfg_m0 && shreg[15:8] == cfg_m1;
            nbits = '0;
            shreg = '0;
            if (ok) begin
              parse_at = PH_EXT_LEN;
            end else begin
              hit = 1'b1;
              d.kind = KIND_BAD_MAGIC;
              d.fin = 1'b1;
              parse_at = PH_DONE;
            end
          end else begin
            nbits++;
          end
        end
        PH_EXT_LEN, PH_PAY_LEN: begin
          if (nbits == 5'd31) begin
            d.value = shreg;
            // a length with the sign bit set means no items
            left = shreg[31] ? 32'd0 : shreg;
            nbits = '0;
            shreg = '0;
            hit = 1'b1;
            if (parse_at == PH_EXT_LEN) begin
              d.kind = KIND_EXT_LEN;
              parse_at = (left != 0) ? PH_EXT_CHR : PH_PAY_LEN;
            end else begin
              d.kind = KIND_PAY_LEN;
              if (left != 0) begin
                parse_at = PH_PAY_CHR;
              end else begin
                d.fin = 1'b1;
                parse_at = PH_DONE;
              end
            end
          end else begin
            nbits++;
          end
        end
        default: begin
          if (nbits == 5'd7) begin
            d.value = {24'd0, shreg[7:0]};
            nbits = '0;
            shreg = '0;
            hit = 1'b1;
            d.kind = (parse_at == PH_EXT_CHR) ? KIND_EXT_CHR : KIND_PAY_CHR;
            if (left != 0) left--;
            if (left == 0) begin
              if (parse_at == PH_EXT_CHR) begin
                parse_at = PH_PAY_LEN;
              end else begin
                d.fin = 1'b1;
                parse_at = PH_DONE;
              end
            end
          end else begin
            nbits++;
          end
        end
      endcase
    end
    // early end overrides whatever this byte completed, unless it already ended the decode
    if (eoi && parse_at != PH_DONE) begin
      hit = 1'b1;
      d.kind = KIND_TRUNC;
      d.value = '0;
      d.fin = 1'b1;
      parse_at = PH_DONE;
      nbits = '0;
      shreg = '0;
    end
    if (hit) begin
      pending.push_back(d);
      results_due++;
    end
  endtask

  // send one image byte request, with random idle cycles ahead of it unless steady is set
  task automatic push_byte(input logic [7:0] b, input logic sof, input logic eoi);
    while (!steady && $urandom_range(0, 99) < 35) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_image_byte <= b;
    in_start_of_image <= sof;
    in_end_of_image <= eoi;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    decode_byte(b, sof, eoi);
    bytes_sent++;
  endtask

  // drop valid and wait for every queued result, plus pipeline slack
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending.size() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_idx_t idx, input logic [7:0] data);
    settle();
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_HEADER_BYTES: cfg_hdr = data;
      CFG_MAGIC_FIRST:  cfg_m0 = data;
      CFG_MAGIC_SECOND: cfg_m1 = data;
      default: ;
    endcase
  endtask

  // hide n bits of v in the LSBs of random carrier bytes, LSB first
  task automatic put_bits(input logic [31:0] v, input int n);
    for (int i = 0; i < n; i++) carrier.push_back({7'($urandom), v[i]});
  endtask

  // lay out a whole stego image; character runs are capped at 40
  task automatic build_image(input int hdr, input logic [7:0] c0, c1,
                             input logic [31:0] elen, plen);
    int n;
    carrier.delete();
    repeat (hdr) carrier.push_back(8'($urandom));
    put_bits(32'({c1, c0}), 16);
    put_bits(elen, LEN_BITS);
    n = elen[31] ? 0 : ((elen > 40) ? 40 : int'(elen));
    repeat (n) put_bits($urandom, CHAR_BITS);
    put_bits(plen, LEN_BITS);
    n = plen[31] ? 0 : ((plen > 40) ? 40 : int'(plen));
    repeat (n) put_bits($urandom, CHAR_BITS);
  endtask

  // send the first upto bytes of the image, end mark optional on the last
  task automatic play(input logic sof, input int upto, input logic eoi);
    for (int i = 0; i < upto; i++)
      push_byte(carrier[i], sof && i == 0, eoi && i == upto - 1);
  endtask

  task automatic send_noise(input int n, input int sof_pct, input int eoi_pct);
    repeat (n)
      push_byte(8'($urandom), $urandom_range(0, 99) < sof_pct,
                $urandom_range(0, 99) < eoi_pct);
  endtask

  function automatic logic [7:0] magic_pick();
    if ($urandom_range(0, 3) == 0) return $urandom_range(0, 1) ? 8'hFF : 8'h00;
    return 8'($urandom);
  endfunction

  // mostly well-formed images, some truncated, some with bad magic, some noise
  task automatic random_image();
    int          r;
    logic [31:0] elen;
    logic [31:0] plen;
    logic [7:0]  c0;
    logic [7:0]  c1;
    c0 = cfg_m0;
    c1 = cfg_m1;
    elen = $urandom_range(0, 4);
    plen = $urandom_range(0, 6);
    if ($urandom_range(0, 9) == 0) elen = {1'b1, 31'($urandom)};
    if ($urandom_range(0, 9) == 0) plen = {1'b1, 31'($urandom)};
    r = $urandom_range(0, 99);
    if (r >= 80 && r < 92) begin
      if ($urandom_range(0, 1)) c0 = c0 ^ 8'(1 << $urandom_range(0, 7));
      else c1 = c1 ^ 8'(1 << $urandom_range(0, 7));
    end
    build_image(int'(cfg_hdr), c0, c1, elen, plen);
    if (r >= 92) begin
      send_noise($urandom_range(1, 30), 25, 25);
    end else if (r >= 65 && r < 80) begin
      play(1'b1, $urandom_range(1, carrier.size()), 1'b1);
    end else begin
      play(1'b1, carrier.size(), 1'($urandom_range(0, 1)));
      if ($urandom_range(0, 2) == 0) send_noise($urandom_range(1, 6), 0, 30);
    end
  endtask

  // image straight after reset, no start mark, reset register values; the end
  // mark on the byte after the magic shows the magic was accepted
  task automatic test_reset_state();
    build_image(HEADER_BYTES_RST, MAGIC_FIRST_RST, MAGIC_SECOND_RST, 32'd1, 32'd2);
    play(1'b0, int'(HEADER_BYTES_RST) + 17, 1'b1);
    settle();
  endtask

  task automatic test_header_extremes();
    write_reg(CFG_HEADER_BYTES, 8'd255);
    build_image(255, cfg_m0, cfg_m1, 32'd0, 32'd0);
    // end mark while still skipping the longest header
    play(1'b1, 20, 1'b1);
    // no header at all for the directed tests that follow
    write_reg(CFG_HEADER_BYTES, 8'd0);
    settle();
  endtask

  task automatic test_magic_check();
    int h;
    h = int'(cfg_hdr);
    write_reg(CFG_MAGIC_FIRST, 8'h00);
    write_reg(CFG_MAGIC_SECOND, 8'hFF);
    // a good magic shows up as a truncation on the byte after it
    build_image(h, 8'h00, 8'hFF, 32'd2, 32'd1);
    play(1'b1, h + 17, 1'b1);
    // wrong first, then wrong second character; the rest is ignored
    build_image(h, 8'h01, 8'hFF, 32'd0, 32'd1);
    play(1'b1, h + 18, 1'b1);
    build_image(h, 8'h00, 8'h7F, 32'd0, 32'd1);
    play(1'b1, h + 18, 1'b1);
    write_reg(CFG_MAGIC_FIRST, 8'hFF);
    write_reg(CFG_MAGIC_SECOND, 8'h00);
    build_image(h, 8'hFF, 8'h00, 32'd1, 32'd1);
    play(1'b1, h + 17, 1'b1);
    settle();
  endtask

  task automatic test_length_cases();
    int h;
    h = int'(cfg_hdr);
    // sign bit set on the extension length: no extension characters; largest
    // positive payload length, cut short inside the first character
    build_image(h, cfg_m0, cfg_m1, 32'h8000_0000, 32'h7FFF_FFFF);
    play(1'b1, h + 80 + 4, 1'b1);
    settle();
  endtask

  task automatic test_truncation();
    int h;
    h = int'(cfg_hdr);
    build_image(h, cfg_m0, cfg_m1, 32'd1, 32'd2);
    play(1'b1, 1, 1'b1);        // start and end on one byte
    play(1'b1, h + 96, 1'b1);   // replaces the first payload character
    // bad magic on the end byte: only the magic error
    build_image(h, ~cfg_m0, cfg_m1, 32'd0, 32'd0);
    play(1'b1, h + 16, 1'b1);
    settle();
  endtask

  task automatic test_restart();
    int h;
    h = int'(cfg_hdr);
    build_image(h, cfg_m0, cfg_m1, 32'd1, 32'd1);
    play(1'b1, h + 20, 1'b0);
    play(1'b1, carrier.size(), 1'b0);
    // after completion bytes and end marks are ignored until a start mark
    send_noise(5, 0, 0);
    send_noise(1, 0, 100);
    play(1'b1, h + 17, 1'b1);
    settle();
  endtask

  task automatic test_random_images();
    int first_bytes;
    first_bytes = bytes_sent;
    while (bytes_sent - first_bytes < 60) begin
      if ($urandom_range(0, 3) == 0) begin
        case ($urandom_range(0, 2))
          0: write_reg(CFG_HEADER_BYTES,
                       ($urandom_range(0, 19) == 0) ? 8'd255 : 8'($urandom_range(0, 12)));
          1: write_reg(CFG_MAGIC_FIRST, magic_pick());
          default: write_reg(CFG_MAGIC_SECOND, magic_pick());
        endcase
      end
      random_image();
    end
  endtask

  // no idling on either side
  task automatic test_back_to_back();
    steady = 1'b1;
    random_image();
    settle();
    steady = 1'b0;
  endtask

  // result side back-pressure
  always @(posedge clk) begin
    if (!rst_n) out_stall <= 1'b0;
    else out_stall <= !steady && $urandom_range(0, 99) < 35;
  end

  function automatic void flag_field(string what, logic [31:0] want_v, logic [31:0] got_v);
    if (want_v !== got_v) begin
      errors++;
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, what, want_v, got_v);
    end
  endfunction

  // scoreboard: each accepted result against the oldest queued one
  always @(posedge clk) begin
    decoded_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending.size() == 0) begin
        errors++;
        $display("%0t: unexpected result, expected none, actual kind %0d value %0h",
                 $time, out_result_kind, out_result_value);
      end else begin
        want = pending.pop_front();
        flag_field("kind", 32'(want.kind), 32'(out_result_kind));
        flag_field("value", want.value, out_result_value);
        flag_field("final", 32'(want.fin), 32'(out_final_result));
        checked++;
        if (want.kind == KIND_TRUNC) n_trunc++;
        if (want.kind == KIND_BAD_MAGIC) n_magic++;
      end
    end
  end

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_state();
    test_header_extremes();
    test_magic_check();
    test_length_cases();
    test_truncation();
    test_restart();
    test_random_images();
    test_back_to_back();
    settle();
    $display("Run: %0d image bytes sent, %0d decoded results checked", bytes_sent, checked);
    $display("Run: %0d truncated images, %0d magic failures", n_trunc, n_magic);
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule

>>> sim.f
sv/lsbx_pkg.sv
sv/lsbx_parser.sv
sv/lsb_stego_payload_extractor.sv
sv/lsbx_checker.sv
test/tb_lsb_stego_payload_extractor.sv
